// File: hdl/pwmss_pkg.sv
// package: shared types and constants of the pwm soft-start controller
`timescale 1ns / 1ps
package pwmss_pkg;

	localparam int CHAN_W      = 4;
	localparam int LEVEL_W     = 12;
	localparam int DELAY_W     = 8;
	localparam int RUN_W       = 16;
	localparam int STAMP_W     = 32;
	localparam int CFG_IDX_W   = 4;
	localparam int CFG_DATA_W  = 12;
	localparam int LV_MASK_W   = 12;

	localparam logic [LEVEL_W-1:0] SPEED_CENTER = 12'd2000;

	localparam logic [LEVEL_W-1:0]   RAMP_INC_RST  = 12'd10;
	localparam logic [DELAY_W-1:0]   RAMP_DELAY_RST = 8'd5;
	localparam logic [LEVEL_W-1:0]   LV_LIMIT_RST  = 12'd500;
	localparam logic [LV_MASK_W-1:0] LV_MASK_RST   = 12'd7;

	typedef enum logic [1:0] {
		DIR_STOP = 2'd0,
		DIR_FWD  = 2'd1,
		DIR_REV  = 2'd2
	} dir_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_RAMP_INC   = 4'd0,
		REG_RAMP_DELAY = 4'd1,
		REG_LV_LIMIT   = 4'd2,
		REG_LV_MASK    = 4'd3
	} cfg_reg_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_CMD,
		ST_BAD,
		ST_TICK
	} state_t;

	typedef struct packed {
		logic [LEVEL_W-1:0]   ramp_inc;
		logic [DELAY_W-1:0]   ramp_delay;
		logic [LEVEL_W-1:0]   lv_limit;
		logic [LV_MASK_W-1:0] lv_mask;
	} cfg_t;

	typedef struct packed {
		logic [LEVEL_W-1:0] target;
		logic [LEVEL_W-1:0] present;
		logic               ramp;
		logic [DELAY_W-1:0] delay;
		dir_t               dir;
		logic               in_use;
		logic [RUN_W-1:0]   run_limit;
		logic [STAMP_W-1:0] stamp;
	} entry_t;

	typedef struct packed {
		logic [LEVEL_W-1:0] fwd;
		logic [LEVEL_W-1:0] rev;
		logic               ramping;
	} chan_rpt_t;

	typedef struct packed {
		logic               req_type;
		logic [CHAN_W-1:0]  motor_number;
		logic [LEVEL_W-1:0] speed;
		logic [RUN_W-1:0]   run_ticks;
	} in_item_t;

	typedef struct packed {
		logic [CHAN_W-1:0]  channel;
		logic [LEVEL_W-1:0] forward_pwm;
		logic [LEVEL_W-1:0] reverse_pwm;
		logic               ramping;
		logic               status;
		logic               last;
	} out_item_t;

endpackage

// File: hdl/pwmss_if.sv
// interfaces: command, result and register write channels
`timescale 1ns / 1ps
interface pwmss_cmd_if;
	logic                 valid;
	logic                 ready;
	pwmss_pkg::in_item_t  data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

interface pwmss_res_if;
	logic                 valid;
	logic                 ready;
	pwmss_pkg::out_item_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

interface pwmss_cfg_if;
	logic                                   valid;
	logic                                   ready;
	logic [pwmss_pkg::CFG_IDX_W-1:0]        index;
	logic [pwmss_pkg::CFG_DATA_W-1:0]       wdata;
	modport source (output valid, output index, output wdata, input ready);
	modport sink (input valid, input index, input wdata, output ready);
endinterface

// File: hdl/pwmss_chan_upd.sv
// channel update: command load or tick ramp step and timeout for one entry
`timescale 1ns / 1ps
module pwmss_chan_upd (
	input  logic                                is_tick,
	input  pwmss_pkg::cfg_t                     cfg_r,
	input  logic                                low_volt,
	input  logic [pwmss_pkg::LEVEL_W-1:0]       speed,
	input  logic [pwmss_pkg::RUN_W-1:0]         run_ticks,
	input  logic [pwmss_pkg::STAMP_W-1:0]       tick_count,
	input  pwmss_pkg::entry_t                   cur,
	output pwmss_pkg::entry_t                   nxt,
	output pwmss_pkg::chan_rpt_t                rpt
);
	import pwmss_pkg::*;

	logic [LEVEL_W-1:0] mag;
	dir_t               dir;
	logic [LEVEL_W:0]   sum;
	logic [STAMP_W-1:0] age;

	always_comb begin
		nxt = cur;
		mag = '0;
		dir = DIR_STOP;
		sum = '0;
		age = '0;
		if (!is_tick) begin
			if (speed < SPEED_CENTER) begin
				mag = SPEED_CENTER - speed;
				dir = DIR_REV;
			end else if (speed > SPEED_CENTER) begin
				mag = speed - SPEED_CENTER;
				dir = DIR_FWD;
			end
			nxt.in_use = 1'b1;
			if (mag != '0) begin
				if (low_volt && mag > cfg_r.lv_limit)
					mag = cfg_r.lv_limit;
				nxt.target  = mag;
				nxt.present = '0;
				nxt.ramp    = (mag != '0);
				nxt.delay   = '0;
				nxt.dir     = dir;
			end else begin
				// stop: drive cleared at once, delay counter kept
				nxt.ramp    = 1'b0;
				nxt.present = '0;
				nxt.target  = '0;
				nxt.dir     = DIR_STOP;
			end
			nxt.run_limit = run_ticks;
			nxt.stamp     = tick_count;
		end else begin
			if (cur.ramp) begin
				nxt.delay = cur.delay + 8'd1;
				if (nxt.delay >= cfg_r.ramp_delay) begin
					nxt.delay = '0;
					if (cur.present < cur.target) begin
						sum = {1'b0, cur.present} + {1'b0, cfg_r.ramp_inc};
						if (sum > {1'b0, cur.target})
							sum = {1'b0, cur.target};
						nxt.present = sum[LEVEL_W-1:0];
						if (sum >= {1'b0, cur.target})
							nxt.ramp = 1'b0;
					end
				end
			end
			// elapsed ticks wrap modulo 2^32
			age = tick_count - cur.stamp;
			if (cur.in_use && age >= {{(STAMP_W-RUN_W){1'b0}}, cur.run_limit}) begin
				nxt.ramp      = 1'b0;
				nxt.present   = '0;
				nxt.target    = '0;
				nxt.dir       = DIR_STOP;
				nxt.in_use    = 1'b0;
				nxt.run_limit = '0;
				nxt.stamp     = '0;
			end
		end
	end

	always_comb begin
		rpt.fwd     = (nxt.dir == DIR_FWD) ? nxt.present : '0;
		rpt.rev     = (nxt.dir == DIR_REV) ? nxt.present : '0;
		rpt.ramping = nxt.ramp;
	end

endmodule

// File: hdl/multichannel_pwm_soft_start.sv
// a command item gives its one result (from ST_CMD, or ST_BAD for a bad motor number),
// held while the result register is full; a tick item gives CHANNEL_COUNT results, one channel
// per cycle while the result register is free, and no new item is taken until ST_IDLE again
// the rate is set by the read-modify-write of the single channel-state memory
// reset (arst_n low) clears all channel entries through per-entry valid bits at once,
// clears the tick counter and loads the register defaults; no clearing pass follows
`timescale 1ns / 1ps
module multichannel_pwm_soft_start #(
	parameter int CHANNEL_COUNT = 12
) (
	input  logic     clk,
	input  logic     arst_n,
	pwmss_cmd_if.sink   cmd,
	pwmss_res_if.source res,
	pwmss_cfg_if.sink   cfg
);
	import pwmss_pkg::*;

	localparam int CH_W = (CHANNEL_COUNT > 1) ? $clog2(CHANNEL_COUNT) : 1;
	localparam logic [CH_W-1:0]   LAST_CH  = CH_W'(CHANNEL_COUNT - 1);
	localparam logic [CHAN_W-1:0] MAX_MOTOR = CHAN_W'(CHANNEL_COUNT);

	state_t              state_q, state_nxt;
	logic [CH_W-1:0]     ch_q;
	logic [LEVEL_W-1:0]  speed_q;
	logic [RUN_W-1:0]    run_ticks_q;
	logic [STAMP_W-1:0]  tick_count_q;
	cfg_t                cfg_q;
	out_item_t           out_q;
	logic                out_vld_q;

	entry_t              mem [CHANNEL_COUNT];
	logic [CHANNEL_COUNT-1:0] valid_q;
	entry_t              rd_data_s1;
	logic                rd_vld_s1;

	logic                cmd_acc;
	logic                out_free;
	logic                motor_ok;
	logic [CH_W-1:0]     cmd_idx;
	logic                rd_en;
	logic [CH_W-1:0]     rd_addr;
	logic                mem_we;
	logic                out_load;
	entry_t              cur;
	entry_t              nxt;
	chan_rpt_t           rpt;
	logic [LV_MASK_W-1:0] lv_sel;
	out_item_t           out_nxt;

	assign cmd_acc  = cmd.valid && cmd.ready;
	assign out_free = !out_vld_q || res.ready;
	assign motor_ok = (cmd.data.motor_number != '0) && (cmd.data.motor_number <= MAX_MOTOR);
	assign cmd_idx  = CH_W'(cmd.data.motor_number - 4'd1);

	assign cfg.ready = 1'b1;
	assign res.valid = out_vld_q;
	assign res.data  = out_q;

	// next state
	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (cmd_acc) begin
					if (cmd.data.req_type)
						state_nxt = ST_TICK;
					else if (motor_ok)
						state_nxt = ST_CMD;
					else
						state_nxt = ST_BAD;
				end
			end
			ST_CMD, ST_BAD: begin
				if (out_free)
					state_nxt = ST_IDLE;
			end
			ST_TICK: begin
				if (out_free && ch_q == LAST_CH)
					state_nxt = ST_IDLE;
			end
			default: state_nxt = ST_IDLE;
		endcase
	end

	// control outputs
	always_comb begin
		cmd.ready = 1'b0;
		rd_en     = 1'b0;
		rd_addr   = ch_q + CH_W'(1);
		mem_we    = 1'b0;
		out_load  = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				cmd.ready = 1'b1;
				rd_en     = cmd.valid && (cmd.data.req_type || motor_ok);
				rd_addr   = cmd.data.req_type ? '0 : cmd_idx;
			end
			ST_CMD: begin
				mem_we   = out_free;
				out_load = out_free;
			end
			ST_BAD: begin
				out_load = out_free;
			end
			ST_TICK: begin
				mem_we   = out_free;
				out_load = out_free;
				// fetch the next channel while this one is written back
				rd_en    = out_free && (ch_q != LAST_CH);
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			ch_q         <= '0;
			tick_count_q <= '0;
			out_vld_q    <= 1'b0;
		end else begin
			state_q <= state_nxt;
			if (cmd_acc) begin
				ch_q <= cmd.data.req_type ? '0 : cmd_idx;
				if (cmd.data.req_type)
					tick_count_q <= tick_count_q + 32'd1;
			end else if (state_q == ST_TICK && out_free && ch_q != LAST_CH) begin
				ch_q <= ch_q + CH_W'(1);
			end
			if (out_load)
				out_vld_q <= 1'b1;
			else if (res.ready)
				out_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd_acc) begin
			speed_q     <= cmd.data.speed;
			run_ticks_q <= cmd.data.run_ticks;
		end
		if (out_load)
			out_q <= out_nxt;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.ramp_inc   <= RAMP_INC_RST;
			cfg_q.ramp_delay <= RAMP_DELAY_RST;
			cfg_q.lv_limit   <= LV_LIMIT_RST;
			cfg_q.lv_mask    <= LV_MASK_RST;
		end else if (cfg.valid && cfg.ready) begin
			unique case (cfg.index)
				REG_RAMP_INC:   cfg_q.ramp_inc   <= cfg.wdata[LEVEL_W-1:0];
				REG_RAMP_DELAY: cfg_q.ramp_delay <= cfg.wdata[DELAY_W-1:0];
				REG_LV_LIMIT:   cfg_q.lv_limit   <= cfg.wdata[LEVEL_W-1:0];
				REG_LV_MASK:    cfg_q.lv_mask    <= cfg.wdata[LV_MASK_W-1:0];
				default: ;
			endcase
		end
	end

	// channel state memory, one read and one write port
	always_ff @(posedge clk) begin
		if (mem_we)
			mem[ch_q] <= nxt;
		if (rd_en) begin
			rd_data_s1 <= mem[rd_addr];
			rd_vld_s1  <= valid_q[rd_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_q <= '0;
		else if (mem_we)
			valid_q[ch_q] <= 1'b1;
	end

	// an entry never written reads as its reset value
	assign cur = rd_vld_s1 ? rd_data_s1 : '0;

	// mask bits past the mask width shift in as zero
	assign lv_sel = cfg_q.lv_mask >> CHAN_W'(ch_q);

	pwmss_chan_upd u_upd (
		.is_tick    (state_q == ST_TICK),
		.cfg_r      (cfg_q),
		.low_volt   (lv_sel[0]),
		.speed      (speed_q),
		.run_ticks  (run_ticks_q),
		.tick_count (tick_count_q),
		.cur        (cur),
		.nxt        (nxt),
		.rpt        (rpt)
	);

	always_comb begin
		out_nxt.channel     = CHAN_W'(ch_q);
		out_nxt.forward_pwm = rpt.fwd;
		out_nxt.reverse_pwm = rpt.rev;
		out_nxt.ramping     = rpt.ramping;
		out_nxt.status      = 1'b0;
		out_nxt.last        = (state_q != ST_TICK) || (ch_q == LAST_CH);
		if (state_q == ST_BAD) begin
			out_nxt.channel     = '0;
			out_nxt.forward_pwm = '0;
			out_nxt.reverse_pwm = '0;
			out_nxt.ramping     = 1'b0;
			out_nxt.status      = 1'b1;
		end
	end

	a_no_rw_collision: assert property (@(posedge clk) disable iff (!arst_n)
		mem_we && rd_en |-> rd_addr != ch_q)
		else $error("memory read and write hit the same channel entry");

	a_tick_counts: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_acc && cmd.data.req_type |=> tick_count_q == $past(tick_count_q) + 32'd1)
		else $error("tick counter did not advance on a tick item");

	a_bad_is_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		res.valid && res.data.status |-> res.data.forward_pwm == '0
			&& res.data.reverse_pwm == '0 && res.data.last)
		else $error("error result carries pwm or is not final");

	a_tick_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_load && state_q == ST_TICK && ch_q == LAST_CH |=> state_q == ST_IDLE)
		else $error("tick sequencer ran past the last channel");

endmodule

// File: sim/tb.sv
// testbench: pwm soft-start controller, directed table then random phases checked by a predictor
`timescale 1ns / 1ps
module tb;
	import pwmss_pkg::*;

	localparam int NCH = 12;
	localparam int DRAIN_CYCLES = 4;
	localparam int ITEMS_PER_PHASE = 39;
	localparam int PHASES = 5;
	localparam logic REQ_CMD = 1'b0;
	localparam logic REQ_TICK = 1'b1;
	localparam logic STATUS_OK = 1'b0;
	localparam logic STATUS_BAD_MOTOR = 1'b1;
	localparam logic [CFG_IDX_W-1:0] REG_UNMAPPED = 4'd9;

	typedef struct {
		logic                  is_reg;
		logic [CFG_IDX_W-1:0]  reg_idx;
		logic [CFG_DATA_W-1:0] reg_val;
		in_item_t              item;
		logic                  typed;
		out_item_t             want;
	} stim_row_t;

	logic clk;
	logic arst_n;
	logic rx_ready = 1'b0;

	pwmss_cmd_if cmd_ch();
	pwmss_res_if res_ch();
	pwmss_cfg_if cfg_ch();

	assign res_ch.ready = rx_ready;

	multichannel_pwm_soft_start #(.CHANNEL_COUNT(NCH)) dut (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd_ch),
		.res    (res_ch),
		.cfg    (cfg_ch)
	);

	// predictor copy of registers and channel state
	logic [LEVEL_W-1:0]   p_inc;
	logic [DELAY_W-1:0]   p_delay;
	logic [LEVEL_W-1:0]   p_lv_limit;
	logic [LV_MASK_W-1:0] p_lv_mask;
	logic [LEVEL_W-1:0]   tgt_lvl [NCH];
	logic [LEVEL_W-1:0]   cur_lvl [NCH];
	logic                 ramp_on [NCH];
	logic [DELAY_W-1:0]   dly_cnt [NCH];
	dir_t                 drv_dir [NCH];
	logic                 in_use  [NCH];
	logic [RUN_W-1:0]     run_lim [NCH];
	logic [STAMP_W-1:0]   t_start [NCH];
	logic [STAMP_W-1:0]   ticks_now;

	out_item_t levels_due[$];

	int tx_idle_pct = 22;
	int rx_idle_pct = 58;
	int fail_count = 0;
	int results_seen = 0;
	int cmds_sent = 0;
	int ticks_sent = 0;
	int reg_writes = 0;

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	initial begin
		#2_000_000;
		$display("Simulation FAILED");
		$finish;
	end

	function automatic void clear_levels(int i);
		ramp_on[i] = 1'b0;
		cur_lvl[i] = '0;
		tgt_lvl[i] = '0;
		drv_dir[i] = DIR_STOP;
	endfunction

	function automatic out_item_t channel_report(int i, logic is_last);
		out_item_t r;
		r.channel = CHAN_W'(i);
		r.forward_pwm = (drv_dir[i] == DIR_FWD) ? cur_lvl[i] : '0;
		r.reverse_pwm = (drv_dir[i] == DIR_REV) ? cur_lvl[i] : '0;
		r.ramping = ramp_on[i];
		r.status = STATUS_OK;
		r.last = is_last;
		return r;
	endfunction

	// updates the predicted state and queues the results one item causes
	function automatic void predict_levels(in_item_t it);
		int i;
		int m;
		logic [LEVEL_W-1:0] mag;
		dir_t dir;
		logic [LEVEL_W:0] nxt;
		out_item_t r;
		if (it.req_type == REQ_CMD) begin
			m = it.motor_number;
			if (m < 1 || m > NCH) begin
				r = '0;
				r.status = STATUS_BAD_MOTOR;
				r.last = 1'b1;
				levels_due.push_back(r);
			end else begin
				i = m - 1;
				if (it.speed < SPEED_CENTER) begin
					mag = SPEED_CENTER - it.speed;
					dir = DIR_REV;
				end else if (it.speed > SPEED_CENTER) begin
					mag = it.speed - SPEED_CENTER;
					dir = DIR_FWD;
				end else begin
					mag = '0;
					dir = DIR_STOP;
				end
				in_use[i] = 1'b1;
				if (mag != '0) begin
					if (p_lv_mask[i] && mag > p_lv_limit)
						mag = p_lv_limit;
					tgt_lvl[i] = mag;
					cur_lvl[i] = '0;
					ramp_on[i] = (mag != '0);
					dly_cnt[i] = '0;
					drv_dir[i] = dir;
				end else begin
					clear_levels(i);
				end
				run_lim[i] = it.run_ticks;
				t_start[i] = ticks_now;
				levels_due.push_back(channel_report(i, 1'b1));
			end
		end else begin
			ticks_now = ticks_now + 1'b1;
			for (int c = 0; c < NCH; c++) begin
				if (ramp_on[c]) begin
					dly_cnt[c] = dly_cnt[c] + 1'b1;
					if (dly_cnt[c] >= p_delay) begin
						dly_cnt[c] = '0;
						if (cur_lvl[c] < tgt_lvl[c]) begin
							nxt = {1'b0, cur_lvl[c]} + {1'b0, p_inc};
							if (nxt > {1'b0, tgt_lvl[c]})
								nxt = {1'b0, tgt_lvl[c]};
							cur_lvl[c] = nxt[LEVEL_W-1:0];
							if (nxt >= {1'b0, tgt_lvl[c]})
								ramp_on[c] = 1'b0;
						end
					end
				end
			end
			// elapsed ticks wrap modulo 2^32; the delay count survives expiry
			for (int c = 0; c < NCH; c++) begin
				if (in_use[c] && (ticks_now - t_start[c]) >= STAMP_W'(run_lim[c])) begin
					clear_levels(c);
					in_use[c] = 1'b0;
					run_lim[c] = '0;
					t_start[c] = '0;
				end
			end
			for (int c = 0; c < NCH; c++)
				levels_due.push_back(channel_report(c, c == NCH - 1));
		end
	endfunction

	function automatic stim_row_t blank_row();
		stim_row_t r;
		r.is_reg = 1'b0;
		r.reg_idx = '0;
		r.reg_val = '0;
		r.item = '0;
		r.typed = 1'b0;
		r.want = '0;
		return r;
	endfunction

	function automatic stim_row_t cmd_row(int m, int s, int run);
		stim_row_t r;
		r = blank_row();
		r.item.req_type = REQ_CMD;
		r.item.motor_number = CHAN_W'(m);
		r.item.speed = LEVEL_W'(s);
		r.item.run_ticks = RUN_W'(run);
		return r;
	endfunction

	// command rows whose single result is known by inspection: levels are zero right after a command
	function automatic stim_row_t typed_row(int m, int s, int run, int ch, logic rmp, logic st);
		stim_row_t r;
		r = cmd_row(m, s, run);
		r.typed = 1'b1;
		r.want.channel = CHAN_W'(ch);
		r.want.ramping = rmp;
		r.want.status = st;
		r.want.last = 1'b1;
		return r;
	endfunction

	function automatic stim_row_t tick_row();
		stim_row_t r;
		r = blank_row();
		r.item.req_type = REQ_TICK;
		return r;
	endfunction

	function automatic stim_row_t reg_row(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
		stim_row_t r;
		r = blank_row();
		r.is_reg = 1'b1;
		r.reg_idx = idx;
		r.reg_val = val;
		return r;
	endfunction

	function automatic in_item_t rand_item();
		in_item_t it;
		int pick;
		it.req_type = ($urandom_range(99) < 45) ? REQ_TICK : REQ_CMD;
		pick = $urandom_range(99);
		if (pick < 88)
			it.motor_number = CHAN_W'($urandom_range(1, NCH));
		else
			it.motor_number = CHAN_W'($urandom_range(0, 15));
		pick = $urandom_range(99);
		if (pick < 12)
			it.speed = SPEED_CENTER;
		else if (pick < 35)
			it.speed = SPEED_CENTER + LEVEL_W'($urandom_range(0, 80)) - LEVEL_W'(40);
		else
			it.speed = LEVEL_W'($urandom_range(0, 4095));
		if ($urandom_range(99) < 70)
			it.run_ticks = RUN_W'($urandom_range(0, 30));
		else
			it.run_ticks = RUN_W'($urandom_range(0, 65535));
		return it;
	endfunction

	task automatic send_item(input in_item_t it, input logic typed, input out_item_t want);
		while ($urandom_range(99) < tx_idle_pct) begin
			cmd_ch.valid <= 1'b0;
			@(posedge clk);
		end
		cmd_ch.valid <= 1'b1;
		cmd_ch.data <= it;
		// ready is looked at mid-cycle, so the following rising edge is the accepting one
		@(negedge clk);
		while (!cmd_ch.ready)
			@(negedge clk);
		@(posedge clk);
		predict_levels(it);
		if (typed) begin
			// the hand-written value stands in for the computed one
			void'(levels_due.pop_back());
			levels_due.push_back(want);
		end
		if (it.req_type == REQ_TICK)
			ticks_sent++;
		else
			cmds_sent++;
	endtask

	// valid stays up on return; callers lower it
	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
		cfg_ch.valid <= 1'b1;
		cfg_ch.index <= idx;
		cfg_ch.wdata <= val;
		@(posedge clk);
		while (!cfg_ch.ready)
			@(posedge clk);
		case (idx)
			REG_RAMP_INC:   p_inc = val;
			REG_RAMP_DELAY: p_delay = val[DELAY_W-1:0];
			REG_LV_LIMIT:   p_lv_limit = val;
			REG_LV_MASK:    p_lv_mask = val;
			default: ;
		endcase
		reg_writes++;
	endtask

	task automatic settle();
		cmd_ch.valid <= 1'b0;
		while (levels_due.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic load_regs(input logic [LEVEL_W-1:0] inc, input logic [DELAY_W-1:0] dly,
			input logic [LEVEL_W-1:0] lim, input logic [LV_MASK_W-1:0] mask);
		settle();
		write_reg(REG_RAMP_INC, inc);
		write_reg(REG_RAMP_DELAY, CFG_DATA_W'(dly));
		write_reg(REG_LV_LIMIT, lim);
		write_reg(REG_LV_MASK, mask);
		cfg_ch.valid <= 1'b0;
	endtask

	task automatic cmp_field(input string name, input int want, input int got);
		if (want != got) begin
			$error("%s: expected %0d, got %0d", name, want, got);
			fail_count++;
		end
	endtask

	always @(posedge clk) begin
		out_item_t want;
		out_item_t got;
		rx_ready <= ($urandom_range(99) >= rx_idle_pct);
		if (arst_n && res_ch.valid && rx_ready) begin
			got = res_ch.data;
			results_seen++;
			if (levels_due.size() == 0) begin
				$error("result with nothing expected: channel %0d", got.channel);
				fail_count++;
			end else begin
				want = levels_due.pop_front();
				cmp_field("channel", want.channel, got.channel);
				cmp_field("forward_pwm", want.forward_pwm, got.forward_pwm);
				cmp_field("reverse_pwm", want.reverse_pwm, got.reverse_pwm);
				cmp_field("ramping", want.ramping, got.ramping);
				cmp_field("status", want.status, got.status);
				cmp_field("last", want.last, got.last);
			end
		end
	end

	initial begin
		stim_row_t plan[$];
		arst_n = 1'b0;
		cmd_ch.valid <= 1'b0;
		cmd_ch.data <= '0;
		cfg_ch.valid <= 1'b0;
		cfg_ch.index <= '0;
		cfg_ch.wdata <= '0;

		p_inc = RAMP_INC_RST;
		p_delay = RAMP_DELAY_RST;
		p_lv_limit = LV_LIMIT_RST;
		p_lv_mask = LV_MASK_RST;
		for (int c = 0; c < NCH; c++) begin
			clear_levels(c);
			dly_cnt[c] = '0;
			in_use[c] = 1'b0;
			run_lim[c] = '0;
			t_start[c] = '0;
		end
		ticks_now = '0;

		// directed part, under reset defaults until the register rows
		plan.push_back(tick_row());
		plan.push_back(typed_row(0, 3000, 10, 0, 1'b0, STATUS_BAD_MOTOR));
		plan.push_back(typed_row(13, 1000, 10, 0, 1'b0, STATUS_BAD_MOTOR));
		plan.push_back(typed_row(15, 4095, 65535, 0, 1'b0, STATUS_BAD_MOTOR));
		plan.push_back(typed_row(1, 0, 65535, 0, 1'b1, STATUS_OK));
		plan.push_back(typed_row(12, 4095, 65535, 11, 1'b1, STATUS_OK));
		plan.push_back(typed_row(4, 1999, 20, 3, 1'b1, STATUS_OK));
		plan.push_back(typed_row(5, 2001, 3, 4, 1'b1, STATUS_OK));
		plan.push_back(typed_row(6, 2000, 8, 5, 1'b0, STATUS_OK));
		// zero run time: cleared on the next tick
		plan.push_back(typed_row(7, 2500, 0, 6, 1'b1, STATUS_OK));
		for (int k = 0; k < 6; k++)
			plan.push_back(tick_row());
		// stop on a channel that is ramping
		plan.push_back(typed_row(1, 2000, 2, 0, 1'b0, STATUS_OK));
		plan.push_back(tick_row());
		// zero increment: ramp stays active and the level never moves
		plan.push_back(reg_row(REG_RAMP_DELAY, 12'd0));
		plan.push_back(reg_row(REG_RAMP_INC, 12'd0));
		plan.push_back(typed_row(2, 1000, 5, 1, 1'b1, STATUS_OK));
		plan.push_back(tick_row());
		plan.push_back(tick_row());
		// low-voltage limit of zero: direction taken but no ramp
		plan.push_back(reg_row(REG_LV_LIMIT, 12'd0));
		plan.push_back(reg_row(REG_LV_MASK, 12'hfff));
		plan.push_back(reg_row(REG_RAMP_INC, 12'd4095));
		plan.push_back(typed_row(9, 4095, 4, 8, 1'b0, STATUS_OK));
		plan.push_back(typed_row(3, 100, 4, 2, 1'b0, STATUS_OK));
		plan.push_back(tick_row());
		// write to an unmapped index must change nothing
		plan.push_back(reg_row(REG_UNMAPPED, 12'habc));
		plan.push_back(tick_row());

		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (plan[k]) begin
			if (plan[k].is_reg) begin
				settle();
				write_reg(plan[k].reg_idx, plan[k].reg_val);
				cfg_ch.valid <= 1'b0;
			end else begin
				send_item(plan[k].item, plan[k].typed, plan[k].want);
			end
		end

		for (int ph = 0; ph < PHASES; ph++) begin
			case (ph)
				0: load_regs(RAMP_INC_RST, RAMP_DELAY_RST, LV_LIMIT_RST, LV_MASK_RST);
				1: load_regs('1, '1, '1, '1);
				2: load_regs('0, '0, '0, '0);
				default: load_regs(LEVEL_W'($urandom_range(1, 400)),
						DELAY_W'($urandom_range(0, 3)),
						LEVEL_W'($urandom_range(0, 4095)),
						LV_MASK_W'($urandom_range(0, 4095)));
			endcase
			if (ph < 2) begin
				tx_idle_pct = 22;
				rx_idle_pct = 58;
			end else if (ph < 4) begin
				tx_idle_pct = 58;
				rx_idle_pct = 22;
			end else begin
				tx_idle_pct = 0;
				rx_idle_pct = 0;
			end
			for (int k = 0; k < ITEMS_PER_PHASE; k++) begin
				if (ph == 2 && k == ITEMS_PER_PHASE / 2)
					settle();
				send_item(rand_item(), 1'b0, '0);
			end
		end

		settle();
		repeat (16) @(posedge clk);

		$display("covered %0d commands and %0d ticks across %0d register writes",
				cmds_sent, ticks_sent, reg_writes);
		$display("%0d results compared field by field, %0d mismatches", results_seen, fail_count);
		if (fail_count == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule

// File: files.f
hdl/pwmss_pkg.sv
hdl/pwmss_if.sv
hdl/pwmss_chan_upd.sv
hdl/multichannel_pwm_soft_start.sv
sim/tb.sv
